@@ rtl/amh_pkg.sv @@
package amh_pkg;

    localparam int MAX_BINS_DEF = 2048;
    localparam int COUNT_BITS_DEF = 32;

    localparam int KIND_W = 2;
    localparam int SAMPLE_W = 16;
    localparam int SELECT_W = 11;
    localparam int CFG_W = 12;
    localparam int OUT_COUNT_W = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 12'd2048;

    localparam int PROD_W = SAMPLE_W + CFG_W;
    localparam int QBITS = CFG_W;
    localparam int STEP_W = $clog2(QBITS);

    typedef enum logic [KIND_W-1:0] {
        KIND_START   = 2'd0,
        KIND_MEASURE = 2'd1,
        KIND_ACCUM   = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_ACC_READ,
        ST_ACC_WRITE,
        ST_READ_OUT
    } state_t;

    typedef struct packed {
        logic clr_max;
        logic upd_max;
        logic load_acc;
        logic div_init;
        logic div_step;
        logic rd_sel;
        logic mem_clear;
        logic mem_incr;
        logic out_load;
    } amh_cmd_t;

    typedef struct packed {
        logic max_zero;
        logic sample_ge;
        logic clr_last;
    } amh_status_t;

endpackage

@@ rtl/amh_ctrl.sv @@
module amh_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            kind,
    input  amh_pkg::amh_status_t  status,
    output amh_pkg::amh_cmd_t     cmd,
    output logic                  busy
);

    amh_pkg::state_t                  state_reg;
    amh_pkg::state_t                  state_next;
    logic [amh_pkg::STEP_W-1:0]       step_reg;
    logic [amh_pkg::STEP_W-1:0]       step_next;
    amh_pkg::kind_t                   kind_code;

    assign kind_code = amh_pkg::kind_t'(kind);
    assign busy = (state_reg != amh_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= amh_pkg::ST_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            amh_pkg::ST_CLEAR:
            begin
                cmd.mem_clear = 1'b1;
                if (status.clr_last)
                begin
                    state_next = amh_pkg::ST_IDLE;
                end
            end
            amh_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (kind_code)
                        amh_pkg::KIND_START:
                        begin
                            cmd.clr_max = 1'b1;
                            state_next  = amh_pkg::ST_CLEAR;
                        end
                        amh_pkg::KIND_MEASURE:
                        begin
                            cmd.upd_max = 1'b1;
                        end
                        amh_pkg::KIND_ACCUM:
                        begin
                            if (!status.max_zero)
                            begin
                                cmd.load_acc = 1'b1;
                                state_next   = amh_pkg::ST_DIV_INIT;
                            end
                        end
                        amh_pkg::KIND_READ:
                        begin
                            cmd.rd_sel = 1'b1;
                            state_next = amh_pkg::ST_READ_OUT;
                        end
                        default:
                        begin
                            state_next = amh_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            amh_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                if (status.sample_ge)
                begin
                    state_next = amh_pkg::ST_ACC_READ;
                end
                else
                begin
                    state_next = amh_pkg::ST_DIV_STEP;
                end
            end
            amh_pkg::ST_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == amh_pkg::STEP_W'(amh_pkg::QBITS - 1))
                begin
                    state_next = amh_pkg::ST_ACC_READ;
                end
            end
            amh_pkg::ST_ACC_READ:
            begin
                state_next = amh_pkg::ST_ACC_WRITE;
            end
            amh_pkg::ST_ACC_WRITE:
            begin
                cmd.mem_incr = 1'b1;
                state_next   = amh_pkg::ST_IDLE;
            end
            amh_pkg::ST_READ_OUT:
            begin
                cmd.out_load = 1'b1;
                state_next   = amh_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = amh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/amh_dpath.sv @@
module amh_dpath
#(
    parameter int MAX_BINS   = amh_pkg::MAX_BINS_DEF,
    parameter int COUNT_BITS = amh_pkg::COUNT_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [amh_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [amh_pkg::SAMPLE_W-1:0] sample,
    input  logic [amh_pkg::SELECT_W-1:0]        bin_select,
    input  amh_pkg::amh_cmd_t                   cmd,
    output amh_pkg::amh_status_t                status,
    output logic [amh_pkg::OUT_COUNT_W-1:0]     bin_count,
    output logic [amh_pkg::SAMPLE_W-1:0]        running_max,
    output logic                                tensor_skipped,
    output logic                                done
);

    localparam int IDX_W = $clog2(MAX_BINS);

    logic [COUNT_BITS-1:0]            mem [MAX_BINS];
    logic [COUNT_BITS-1:0]            rd_data_reg;

    logic [amh_pkg::CFG_W-1:0]        cfg_reg;
    logic [amh_pkg::SAMPLE_W-1:0]     largest_reg;
    logic [amh_pkg::SAMPLE_W-1:0]     largest_next;
    logic [IDX_W-1:0]                 clr_cnt_reg;
    logic [IDX_W-1:0]                 clr_cnt_next;
    logic                             done_reg;

    logic [amh_pkg::PROD_W-1:0]       prod_reg;
    logic                             ge_reg;
    logic [amh_pkg::CFG_W-1:0]        bins_reg;
    logic [amh_pkg::SAMPLE_W-1:0]     rem_reg;
    logic [amh_pkg::QBITS-1:0]        low_reg;
    logic [amh_pkg::QBITS-1:0]        quot_reg;
    logic [IDX_W-1:0]                 idx_reg;
    logic                             oob_reg;

    logic [amh_pkg::OUT_COUNT_W-1:0]  bin_count_reg;
    logic [amh_pkg::SAMPLE_W-1:0]     running_max_reg;
    logic                             skipped_reg;

    logic [amh_pkg::SAMPLE_W-1:0]     sample_bits;
    logic [amh_pkg::SAMPLE_W-1:0]     mag;
    logic [amh_pkg::CFG_W-1:0]        bins_eff;
    logic [amh_pkg::SAMPLE_W:0]       trial;
    logic [amh_pkg::SAMPLE_W:0]       divisor;
    logic [amh_pkg::SAMPLE_W:0]       diff;
    logic [amh_pkg::QBITS-1:0]        idx_calc;
    logic [31:0]                      idx_wide;
    logic [31:0]                      sel_wide;
    logic [IDX_W-1:0]                 sel_idx;
    logic                             sel_oob;
    logic [IDX_W-1:0]                 raddr;
    logic [IDX_W-1:0]                 waddr;
    logic [COUNT_BITS-1:0]            wdata;
    logic                             mem_we;
    logic [COUNT_BITS-1:0]            incr;
    logic [63:0]                      count_wide;

    assign sample_bits = sample;
    assign mag = sample_bits[amh_pkg::SAMPLE_W-1] ? (~sample_bits + 1'b1) : sample_bits;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            bins_eff = amh_pkg::CFG_W'(1);
        end
        else if (32'(cfg_reg) > 32'(MAX_BINS))
        begin
            bins_eff = amh_pkg::CFG_W'(MAX_BINS);
        end
        else
        begin
            bins_eff = cfg_reg;
        end
    end

    assign divisor = {1'b0, largest_reg};
    assign trial   = {rem_reg, low_reg[amh_pkg::QBITS-1]};
    assign diff    = trial - divisor;

    assign idx_calc = ge_reg ? (bins_reg - 1'b1) : quot_reg;
    assign idx_wide = 32'(idx_calc);
    assign sel_wide = 32'(bin_select);
    assign sel_idx  = sel_wide[IDX_W-1:0];
    assign sel_oob  = (sel_wide >= 32'(MAX_BINS));

    assign raddr  = cmd.rd_sel ? sel_idx : idx_wide[IDX_W-1:0];
    assign incr   = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + COUNT_BITS'(1);
    assign mem_we = cmd.mem_clear || cmd.mem_incr;
    assign waddr  = cmd.mem_clear ? clr_cnt_reg : idx_reg;
    assign wdata  = cmd.mem_clear ? '0 : incr;

    assign count_wide = 64'(rd_data_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_comb
    begin
        largest_next = largest_reg;
        if (cmd.clr_max)
        begin
            largest_next = '0;
        end
        else if (cmd.upd_max && (mag > largest_reg))
        begin
            largest_next = mag;
        end
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.mem_clear)
        begin
            if (status.clr_last)
            begin
                clr_cnt_next = '0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= amh_pkg::CFG_RESET;
            largest_reg <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            largest_reg <= largest_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= cmd.out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_acc)
        begin
            prod_reg <= amh_pkg::PROD_W'(mag) * amh_pkg::PROD_W'(bins_eff);
            ge_reg   <= (mag >= largest_reg);
            bins_reg <= bins_eff;
        end
        if (cmd.div_init)
        begin
            rem_reg  <= prod_reg[amh_pkg::PROD_W-1:amh_pkg::QBITS];
            low_reg  <= prod_reg[amh_pkg::QBITS-1:0];
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            low_reg <= {low_reg[amh_pkg::QBITS-2:0], 1'b0};
            if (trial >= divisor)
            begin
                rem_reg  <= diff[amh_pkg::SAMPLE_W-1:0];
                quot_reg <= {quot_reg[amh_pkg::QBITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial[amh_pkg::SAMPLE_W-1:0];
                quot_reg <= {quot_reg[amh_pkg::QBITS-2:0], 1'b0};
            end
        end
        if (cmd.rd_sel)
        begin
            oob_reg <= sel_oob;
        end
        if (!cmd.rd_sel)
        begin
            idx_reg <= idx_wide[IDX_W-1:0];
        end
        if (cmd.out_load)
        begin
            if (oob_reg)
            begin
                bin_count_reg <= '0;
            end
            else if (count_wide > 64'hFFFF_FFFF)
            begin
                bin_count_reg <= 32'hFFFF_FFFF;
            end
            else
            begin
                bin_count_reg <= count_wide[31:0];
            end
            running_max_reg <= largest_reg;
            skipped_reg     <= (largest_reg == '0);
        end
    end

    assign status.max_zero  = (largest_reg == '0);
    assign status.sample_ge = ge_reg;
    assign status.clr_last  = (clr_cnt_reg == IDX_W'(MAX_BINS - 1));

    assign bin_count      = bin_count_reg;
    assign running_max    = running_max_reg;
    assign tensor_skipped = skipped_reg;
    assign done           = done_reg;

endmodule

@@ rtl/absmax_scaled_histogram.sv @@
// Channel   Handshake              Contents
// command   start / busy           kind, sample, bin_select
// result    done (one-cycle pulse) bin_count, running_max, tensor_skipped
// config    cfg_valid / cfg_ready  cfg_data (bins in use)
//
// Measure words leave busy low. A read word captures the selected bin in the read
// register and raises busy while its result is loaded into the result registers, with
// done. An accumulate word keeps busy high through the divider set-up, the 12-step
// restoring divider and the bin read and write, skipping the divider steps when the
// sample is at or above the maximum; with a zero maximum it leaves busy low. A start
// word, and reset, run a clearing pass over the bin memory, one entry per cycle, with
// busy high. Results cannot be stalled; cfg_ready is always high.
module absmax_scaled_histogram
#(
    parameter int MAX_BINS   = amh_pkg::MAX_BINS_DEF,
    parameter int COUNT_BITS = amh_pkg::COUNT_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [amh_pkg::KIND_W-1:0]          kind,
    input  logic signed [amh_pkg::SAMPLE_W-1:0] sample,
    input  logic [amh_pkg::SELECT_W-1:0]        bin_select,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [amh_pkg::CFG_W-1:0]           cfg_data,
    output logic                                done,
    output logic [amh_pkg::OUT_COUNT_W-1:0]     bin_count,
    output logic [amh_pkg::SAMPLE_W-1:0]        running_max,
    output logic                                tensor_skipped
);

    amh_pkg::amh_cmd_t    cmd;
    amh_pkg::amh_status_t status;

    assign cfg_ready = 1'b1;

    amh_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    amh_dpath
    #(
        .MAX_BINS   (MAX_BINS),
        .COUNT_BITS (COUNT_BITS)
    )
    u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .sample         (sample),
        .bin_select     (bin_select),
        .cmd            (cmd),
        .status         (status),
        .bin_count      (bin_count),
        .running_max    (running_max),
        .tensor_skipped (tensor_skipped),
        .done           (done)
    );

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("Result strobe without a preceding busy cycle.");

    a_read_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == amh_pkg::KIND_READ) |=> busy)
        else $error("Accepted read word did not raise busy.");

    a_read_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == amh_pkg::KIND_READ) |=> ##1 done)
        else $error("Read result did not appear two cycles after acceptance.");

    a_skip_matches_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (tensor_skipped == (running_max == '0)))
        else $error("Skip flag disagrees with the reported maximum.");
`endif

endmodule

@@ verif/histogram_checker.sv @@
`timescale 1ns / 1ps

module histogram_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [amh_pkg::KIND_W-1:0]          kind,
    input  logic signed [amh_pkg::SAMPLE_W-1:0] sample,
    input  logic [amh_pkg::SELECT_W-1:0]        bin_select,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [amh_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                done,
    input  logic [amh_pkg::OUT_COUNT_W-1:0]     bin_count,
    input  logic [amh_pkg::SAMPLE_W-1:0]        running_max,
    input  logic                                tensor_skipped,
    output int                                  mismatches,
    output int                                  reports_due
);

    typedef struct packed {
        logic [amh_pkg::OUT_COUNT_W-1:0] count;
        logic [amh_pkg::SAMPLE_W-1:0]    peak;
        logic                            skipped;
    } bin_report_t;

    logic [amh_pkg::CFG_W-1:0]       bins_reg;
    logic [amh_pkg::SAMPLE_W-1:0]    peak_mag;
    logic [amh_pkg::OUT_COUNT_W-1:0] bin_counts [amh_pkg::MAX_BINS_DEF];
    bin_report_t                     open_reports [$];
    bin_report_t                     oldest;
    int                              errors;
    int                              shown;

    function automatic void clear_tensor();
        peak_mag = '0;
        for (int i = 0; i < amh_pkg::MAX_BINS_DEF; i++)
        begin
            bin_counts[i] = '0;
        end
    endfunction

    function automatic void predict_word(input amh_pkg::kind_t k,
                                         input logic [amh_pkg::SAMPLE_W-1:0] s,
                                         input logic [amh_pkg::SELECT_W-1:0] sel);
        logic [amh_pkg::SAMPLE_W:0]                slot_mag;
        logic [amh_pkg::CFG_W-1:0]                 span;
        logic [amh_pkg::SAMPLE_W+amh_pkg::CFG_W:0] slot;
        bin_report_t                               r;
        slot_mag = s[amh_pkg::SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
        if (bins_reg == 0)
            span = amh_pkg::CFG_W'(1);
        else if (bins_reg > amh_pkg::MAX_BINS_DEF)
            span = amh_pkg::CFG_W'(amh_pkg::MAX_BINS_DEF);
        else
            span = bins_reg;
        case (k)
            amh_pkg::KIND_START:
            begin
                clear_tensor();
            end
            amh_pkg::KIND_MEASURE:
            begin
                if (slot_mag > peak_mag)
                    peak_mag = slot_mag[amh_pkg::SAMPLE_W-1:0];
            end
            amh_pkg::KIND_ACCUM:
            begin
                if (peak_mag != 0)
                begin
                    slot = (slot_mag * span) / peak_mag;
                    if (slot >= span)
                        slot = span - 1;
                    if (bin_counts[slot] != '1)
                        bin_counts[slot] = bin_counts[slot] + 1;
                end
            end
            default:
            begin
                r.count = bin_counts[sel];
                r.peak = peak_mag;
                r.skipped = (peak_mag == 0);
                open_reports = {open_reports, r};
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_reg = amh_pkg::CFG_RESET;
            clear_tensor();
            open_reports.delete();
            reports_due <= 0;
        end
        else
        begin
            if (done)
            begin
                if (open_reports.size() == 0)
                begin
                    errors++;
                    if (shown < 10)
                        $display("unexpected result word: count %0d max %0d skipped %0b",
                                 bin_count, running_max, tensor_skipped);
                    shown++;
                end
                else
                begin
                    oldest = open_reports.pop_front();
                    if (oldest.count !== bin_count || oldest.peak !== running_max ||
                        oldest.skipped !== tensor_skipped)
                    begin
                        errors++;
                        if (shown < 10)
                            $display("result word mismatch: expected count %0d max %0d ",
                                     oldest.count, oldest.peak,
                                     "skipped %0b, got count %0d max %0d skipped %0b",
                                     oldest.skipped, bin_count, running_max,
                                     tensor_skipped);
                        shown++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                bins_reg = cfg_data;
            if (start && !busy)
                predict_word(amh_pkg::kind_t'(kind), sample, bin_select);
            reports_due <= open_reports.size();
        end
        mismatches <= errors;
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int QUIET_LIMIT = 10000;
    localparam int PHASES = 12;
    localparam int WORDS_PER_PHASE = 64;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [amh_pkg::KIND_W-1:0]          kind = '0;
    logic signed [amh_pkg::SAMPLE_W-1:0] sample = '0;
    logic [amh_pkg::SELECT_W-1:0]        bin_select = '0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [amh_pkg::CFG_W-1:0]           cfg_data = '0;
    logic                                done;
    logic [amh_pkg::OUT_COUNT_W-1:0]     bin_count;
    logic [amh_pkg::SAMPLE_W-1:0]        running_max;
    logic                                tensor_skipped;
    int                                  mismatches;
    int                                  reports_due;

    int idle_pct = 0;
    int words_sent = 0;
    int cur_span = amh_pkg::MAX_BINS_DEF;
    int quiet_cycles = 0;

    absmax_scaled_histogram i_dut (.*);

    histogram_checker i_checker (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [amh_pkg::SAMPLE_W-1:0] draw_sample(input int w);
        logic [amh_pkg::SAMPLE_W-1:0] v;
        v = 16'($urandom) & 16'((32'd1 << w) - 1);
        if (w < amh_pkg::SAMPLE_W && $urandom_range(1) == 1)
            v = -v;
        return v;
    endfunction

    task automatic issue(input amh_pkg::kind_t k, input logic [amh_pkg::SAMPLE_W-1:0] s,
                         input logic [amh_pkg::SELECT_W-1:0] sel);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        kind <= k;
        sample <= s;
        bin_select <= sel;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
    endtask

    // The bin count is only changed once all reads are back and the block is idle.
    task automatic set_bins(input logic [amh_pkg::CFG_W-1:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (v == 0)
            cur_span = 1;
        else if (v > amh_pkg::MAX_BINS_DEF)
            cur_span = amh_pkg::MAX_BINS_DEF;
        else
            cur_span = int'(v);
    endtask

    task automatic run_tensor();
        int w;
        int n_meas;
        int n_acc;
        int n_read;
        w = $urandom_range(1, amh_pkg::SAMPLE_W);
        n_meas = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
        n_acc = $urandom_range(4, 24);
        n_read = $urandom_range(2, 8);
        issue(amh_pkg::KIND_START, 16'($urandom), 11'($urandom));
        repeat (n_meas) issue(amh_pkg::KIND_MEASURE, draw_sample(w), 11'($urandom));
        while (n_acc + n_read > 0)
        begin
            if (n_read == 0 || (n_acc > 0 && $urandom_range(n_acc + n_read - 1) < n_acc))
            begin
                issue(amh_pkg::KIND_ACCUM, ($urandom_range(9) == 0)
                                           ? draw_sample(amh_pkg::SAMPLE_W)
                                           : draw_sample(w),
                      11'($urandom));
                n_acc--;
            end
            else
            begin
                issue(amh_pkg::KIND_READ, 16'($urandom),
                      ($urandom_range(3) == 0) ? 11'($urandom)
                                               : 11'($urandom_range(cur_span - 1)));
                n_read--;
            end
        end
    endtask

    initial
    begin
        int target;
        logic [amh_pkg::CFG_W-1:0] v;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        set_bins(amh_pkg::CFG_RESET);
        idle_pct = 35;

        issue(amh_pkg::KIND_READ, 16'h0000, 11'd0);
        issue(amh_pkg::KIND_ACCUM, 16'h0100, 11'd0);
        issue(amh_pkg::KIND_READ, 16'hFFFF, 11'd2047);
        issue(amh_pkg::KIND_MEASURE, 16'h8000, 11'h7FF);
        issue(amh_pkg::KIND_MEASURE, 16'h7FFF, 11'd0);
        issue(amh_pkg::KIND_MEASURE, 16'h0000, 11'd0);
        issue(amh_pkg::KIND_ACCUM, 16'h8000, 11'd0);
        issue(amh_pkg::KIND_ACCUM, 16'h7FFF, 11'd0);
        issue(amh_pkg::KIND_ACCUM, 16'h0000, 11'd0);
        issue(amh_pkg::KIND_ACCUM, 16'hFFFF, 11'd0);
        issue(amh_pkg::KIND_ACCUM, 16'h4000, 11'd0);
        issue(amh_pkg::KIND_READ, 16'h0000, 11'd0);
        issue(amh_pkg::KIND_READ, 16'h0000, 11'd1024);
        issue(amh_pkg::KIND_READ, 16'h0000, 11'd2047);
        issue(amh_pkg::KIND_READ, 16'h0000, 11'd2046);
        issue(amh_pkg::KIND_START, 16'hFFFF, 11'h7FF);
        issue(amh_pkg::KIND_READ, 16'h0000, 11'd0);
        issue(amh_pkg::KIND_MEASURE, 16'h0001, 11'd0);
        issue(amh_pkg::KIND_ACCUM, 16'h0001, 11'd0);
        issue(amh_pkg::KIND_ACCUM, 16'hFFFF, 11'd0);
        issue(amh_pkg::KIND_ACCUM, 16'h012C, 11'd0);
        issue(amh_pkg::KIND_ACCUM, 16'h0000, 11'd0);
        issue(amh_pkg::KIND_READ, 16'h0000, 11'd2047);
        issue(amh_pkg::KIND_READ, 16'h0000, 11'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: v = 12'd1;
                1: v = 12'd0;
                2: v = 12'd4095;
                3: v = 12'd2048;
                4: v = 12'd2;
                default: v = ($urandom_range(1) == 1) ? 12'($urandom_range(1, 16))
                                                      : 12'($urandom_range(4095));
            endcase
            set_bins(v);
            idle_pct = (p < PHASES / 3) ? 35 : (p < 2 * PHASES / 3) ? 68 : 0;
            target = words_sent + WORDS_PER_PHASE;
            while (words_sent < target)
            begin
                if ($urandom_range(99) < 85)
                    run_tensor();
                else
                    issue(amh_pkg::kind_t'($urandom_range(3)), 16'($urandom),
                          11'($urandom));
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (reports_due != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/amh_pkg.sv
rtl/amh_ctrl.sv
rtl/amh_dpath.sv
rtl/absmax_scaled_histogram.sv
verif/histogram_checker.sv
verif/tb.sv
